// ===== hdl/fscl_pkg.sv =====
// Package for the slave-serial configuration loader: phase, action and status codes,
// register indexes, reset values and the structs passed between the modules.
// Depends on nothing; every other file of the block uses it.
package fscl_pkg;

	// Width of the byte counter; it saturates at its largest value.
	localparam int COUNT_WIDTH = 24;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam int CFG_DATA_WIDTH = 24;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_RESET_WAIT = 3'd1,
		PH_RELEASE    = 3'd2,
		PH_INIT_WAIT  = 3'd3,
		PH_DELAY      = 3'd4,
		PH_SHIFT      = 3'd5,
		PH_TRAIL      = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_STEP  = 2'd1,
		ACT_BYTE  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_NONE          = 3'd0,
		ST_BUSY          = 3'd1,
		ST_SUCCESS       = 3'd2,
		ST_RESET_TIMEOUT = 3'd3,
		ST_INIT_TIMEOUT  = 3'd4,
		ST_ABORTED       = 3'd5,
		ST_OVERRUN       = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CFG_TIMEOUT_TICKS     = 2'd0,
		CFG_MAX_BYTES         = 2'd1,
		CFG_START_DELAY_TICKS = 2'd2,
		CFG_TRAILING_CLOCKS   = 2'd3
	} cfg_index_t;

	localparam logic [15:0] RST_TIMEOUT_TICKS     = 16'd1000;
	localparam logic [23:0] RST_MAX_BYTES         = 24'd212492;
	localparam logic [7:0]  RST_START_DELAY_TICKS = 8'd4;
	localparam logic [7:0]  RST_TRAILING_CLOCKS   = 8'd10;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [23:0] max_bytes;
		logic [7:0]  start_delay_ticks;
		logic [7:0]  trailing_clocks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] byte_value;
		logic       init_level;
		logic       done_level;
	} item_t;

	typedef struct packed {
		logic       prog_drive;
		logic       data_bit;
		logic       clock_pulse;
		logic       need_byte;
		logic [2:0] status;
	} result_t;

endpackage

// ===== hdl/fscl_cfg.sv =====
// Configuration register file of the slave-serial loader.
// Depends on fscl_pkg for the register indexes, reset values and cfg_t.
module fscl_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [1:0]                          wr_index,
	input  logic [fscl_pkg::CFG_DATA_WIDTH-1:0] wr_data,
	output fscl_pkg::cfg_t                      cfg
);

	fscl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks     <= fscl_pkg::RST_TIMEOUT_TICKS;
			cfg_q.max_bytes         <= fscl_pkg::RST_MAX_BYTES;
			cfg_q.start_delay_ticks <= fscl_pkg::RST_START_DELAY_TICKS;
			cfg_q.trailing_clocks   <= fscl_pkg::RST_TRAILING_CLOCKS;
		end else if (wr_en) begin
			case (fscl_pkg::cfg_index_t'(wr_index))
				fscl_pkg::CFG_TIMEOUT_TICKS:     cfg_q.timeout_ticks     <= wr_data[15:0];
				fscl_pkg::CFG_MAX_BYTES:         cfg_q.max_bytes         <= wr_data[23:0];
				fscl_pkg::CFG_START_DELAY_TICKS: cfg_q.start_delay_ticks <= wr_data[7:0];
				fscl_pkg::CFG_TRAILING_CLOCKS:   cfg_q.trailing_clocks   <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/fscl_seq.sv =====
// Sequencer state and next-state logic of the slave-serial loader: one item per enable.
// Depends on fscl_pkg for the phase, action and status codes and the item structs.
module fscl_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  fscl_pkg::cfg_t    cfg,
	input  fscl_pkg::item_t   item,
	output fscl_pkg::result_t result
);

	fscl_pkg::phase_t                ph_q, ph_d;
	fscl_pkg::status_t               ls_q, ls_d;
	logic [15:0]                     wc_q, wc_d;
	logic [7:0]                      sb_q, sb_d;
	logic [3:0]                      bi_q, bi_d;
	logic [fscl_pkg::COUNT_WIDTH-1:0] bc_q, bc_d;
	logic                            bl_q, bl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= fscl_pkg::PH_IDLE;
			ls_q <= fscl_pkg::ST_NONE;
			wc_q <= '0;
			sb_q <= '0;
			bi_q <= '0;
			bc_q <= '0;
			bl_q <= 1'b0;
		end else if (step_en) begin
			ph_q <= ph_d;
			ls_q <= ls_d;
			wc_q <= wc_d;
			sb_q <= sb_d;
			bi_q <= bi_d;
			bc_q <= bc_d;
			bl_q <= bl_d;
		end
	end

	always_comb begin
		logic [15:0] wc_inc;
		logic [3:0]  bi_inc;
		logic        byte_end;
		logic        bit_o;
		logic        clk_o;

		ph_d     = ph_q;
		ls_d     = ls_q;
		wc_d     = wc_q;
		sb_d     = sb_q;
		bi_d     = bi_q;
		bc_d     = bc_q;
		bl_d     = bl_q;
		wc_inc   = wc_q + 16'd1;
		bi_inc   = bi_q + 4'd1;
		byte_end = 1'b0;
		bit_o    = 1'b0;
		clk_o    = 1'b0;

		case (fscl_pkg::action_t'(item.action))
			fscl_pkg::ACT_START: begin
				ph_d = fscl_pkg::PH_RESET_WAIT;
				wc_d = '0;
				sb_d = '0;
				bi_d = '0;
				bc_d = '0;
				bl_d = 1'b0;
			end
			fscl_pkg::ACT_BYTE: begin
				if (ph_q == fscl_pkg::PH_SHIFT && !bl_q) begin
					sb_d = item.byte_value;
					bi_d = '0;
					bl_d = 1'b1;
				end
			end
			fscl_pkg::ACT_STEP: begin
				case (ph_q)
					fscl_pkg::PH_RESET_WAIT: begin
						if (!item.init_level && !item.done_level) begin
							ph_d = fscl_pkg::PH_RELEASE;
						end else if (wc_q >= cfg.timeout_ticks) begin
							ph_d = fscl_pkg::PH_IDLE;
							ls_d = fscl_pkg::ST_RESET_TIMEOUT;
							bl_d = 1'b0;
						end else begin
							wc_d = wc_inc;
						end
					end
					fscl_pkg::PH_RELEASE: begin
						ph_d = fscl_pkg::PH_INIT_WAIT;
						wc_d = '0;
					end
					fscl_pkg::PH_INIT_WAIT: begin
						if (item.init_level) begin
							wc_d = '0;
							ph_d = (cfg.start_delay_ticks == 8'd0) ? fscl_pkg::PH_SHIFT
							                                      : fscl_pkg::PH_DELAY;
						end else if (wc_q >= cfg.timeout_ticks) begin
							ph_d = fscl_pkg::PH_IDLE;
							ls_d = fscl_pkg::ST_INIT_TIMEOUT;
							bl_d = 1'b0;
						end else begin
							wc_d = wc_inc;
						end
					end
					fscl_pkg::PH_DELAY: begin
						if (wc_inc >= {8'd0, cfg.start_delay_ticks}) begin
							wc_d = '0;
							ph_d = fscl_pkg::PH_SHIFT;
						end else begin
							wc_d = wc_inc;
						end
					end
					fscl_pkg::PH_SHIFT: begin
						if (bl_q) begin
							bit_o    = sb_q[7];
							clk_o    = 1'b1;
							sb_d     = {sb_q[6:0], 1'b0};
							bi_d     = bi_inc;
							byte_end = (bi_inc >= 4'd8) || item.done_level;
							if (byte_end) begin
								bl_d = 1'b0;
								bi_d = '0;
								if (bc_q != fscl_pkg::COUNT_MAX) begin
									bc_d = bc_q + 1'b1;
								end
							end
							if (item.done_level) begin
								wc_d = '0;
								if (cfg.trailing_clocks == 8'd0) begin
									ph_d = fscl_pkg::PH_IDLE;
									ls_d = fscl_pkg::ST_SUCCESS;
									bl_d = 1'b0;
								end else begin
									ph_d = fscl_pkg::PH_TRAIL;
								end
							end else if (!item.init_level) begin
								ph_d = fscl_pkg::PH_IDLE;
								ls_d = fscl_pkg::ST_ABORTED;
								bl_d = 1'b0;
							end else if (byte_end && ({{(33-fscl_pkg::COUNT_WIDTH){1'b0}}, bc_d}
							             > {9'd0, cfg.max_bytes})) begin
								ph_d = fscl_pkg::PH_IDLE;
								ls_d = fscl_pkg::ST_OVERRUN;
								bl_d = 1'b0;
							end
						end
					end
					fscl_pkg::PH_TRAIL: begin
						clk_o = 1'b1;
						wc_d  = wc_inc;
						if (wc_inc >= {8'd0, cfg.trailing_clocks}) begin
							ph_d = fscl_pkg::PH_IDLE;
							ls_d = fscl_pkg::ST_SUCCESS;
							bl_d = 1'b0;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		result.prog_drive  = !(ph_d == fscl_pkg::PH_RESET_WAIT || ph_d == fscl_pkg::PH_RELEASE);
		result.data_bit    = bit_o;
		result.clock_pulse = clk_o;
		result.need_byte   = (ph_d == fscl_pkg::PH_SHIFT) && !bl_d;
		result.status      = (ph_d == fscl_pkg::PH_IDLE) ? ls_d : fscl_pkg::ST_BUSY;
	end

endmodule

// ===== hdl/fpga_serial_config_loader_core.sv =====
// Top level of the slave-serial FPGA configuration loader: input register, sequencer,
// result register and configuration port. Depends on fscl_pkg, fscl_cfg and fscl_seq.
//
// The loader takes one item per clock cycle while in_stall is low, and returns exactly
// one result item for each, in order. An accepted item is held in an input register;
// the sequencer then works out the new phase and the line levels from it and its own
// state, and the result lands in the output register, from which it is offered. The
// sequencer state is updated once per step: an item may follow in every cycle, and
// the input stays open while a result waits in the output register, as long as the
// input register can move on. When the output is stalled and both registers are
// full, in_stall goes high until the result is taken. Configuration writes are
// always ready and take effect at once; write them only while no item is in flight.
// Status reads 1 while a sequence runs and holds the last end status (success,
// reset timeout, init timeout, aborted, overrun) once idle.
module fpga_serial_config_loader_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// item input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          action,
	input  logic [7:0]                          byte_value,
	input  logic                                init_level,
	input  logic                                done_level,
	// result output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                prog_drive,
	output logic                                data_bit,
	output logic                                clock_pulse,
	output logic                                need_byte,
	output logic [2:0]                          status,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [fscl_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

	fscl_pkg::cfg_t    cfg;
	fscl_pkg::item_t   item_s1;
	fscl_pkg::result_t seq_result;
	fscl_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;
	logic              step_en;
	logic              in_accept;

	// The result register can take a new result when it is empty or being emptied.
	assign advance   = !valid_s2 || !out_stall;
	assign step_en   = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	fscl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input register: holds one item until the sequencer consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.action     <= action;
			item_s1.byte_value <= byte_value;
			item_s1.init_level <= init_level;
			item_s1.done_level <= done_level;
		end
	end

	// The sequencer state moves on exactly when the item in the input register does.
	fscl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(step_en),
		.cfg    (cfg),
		.item   (item_s1),
		.result (seq_result)
	);

	// Result register: keeps a finished result steady while the output is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= seq_result;
		end
	end

	assign out_valid   = valid_s2;
	assign prog_drive  = res_s2.prog_drive;
	assign data_bit    = res_s2.data_bit;
	assign clock_pulse = res_s2.clock_pulse;
	assign need_byte   = res_s2.need_byte;
	assign status      = res_s2.status;

endmodule

// ===== hdl/fscl_checker.sv =====
// Port-level checker for the slave-serial loader, bound to the top level.
// Depends on fscl_pkg for the status codes and on the top level's port names.
module fscl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       prog_drive,
	input logic       data_bit,
	input logic       clock_pulse,
	input logic       need_byte,
	input logic [2:0] status
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// A data bit is only ever driven together with a clock pulse.
	a_bit_with_clock: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_bit |-> clock_pulse)
		else $error("data bit without clock pulse");

	// The program line is held low only while a sequence runs.
	a_prog_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !prog_drive |-> status == fscl_pkg::ST_BUSY)
		else $error("program line low while idle");

	// A byte is requested only while shifting, with the program line released.
	a_need_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && need_byte |-> prog_drive && status == fscl_pkg::ST_BUSY)
		else $error("byte request outside shifting");

endmodule

bind fpga_serial_config_loader_core fscl_checker u_fscl_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for fpga_serial_config_loader_core: directed table, then random
// configuration sequences checked against a line-level predictor. Depends on fscl_pkg and
// the loader RTL only.
module testbench;
	import fscl_pkg::*;

	// Quiet cycles (no item, result or register write accepted) before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 2000;
	// Length of the long receiver hold-off that fills the loader and stalls its input.
	localparam int HOLD_CYCLES    = 80;
	localparam int PHASE_ITEMS    = 190;
	localparam int PHASE_COUNT    = 8;
	localparam int DIR_ROWS       = 20;

	// One directed row: an item and, where it is obvious, the line levels it must give.
	typedef struct packed {
		item_t   it;
		logic    typed;
		result_t want;
	} dir_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [1:0]                action;
	logic [7:0]                byte_value;
	logic                      init_level;
	logic                      done_level;
	logic                      out_valid;
	logic                      out_stall;
	logic                      prog_drive;
	logic                      data_bit;
	logic                      clock_pulse;
	logic                      need_byte;
	logic [2:0]                status;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [1:0]                cfg_index;
	logic [CFG_DATA_WIDTH-1:0] cfg_data;

	fpga_serial_config_loader_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.byte_value  (byte_value),
		.init_level  (init_level),
		.done_level  (done_level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.prog_drive  (prog_drive),
		.data_bit    (data_bit),
		.clock_pulse (clock_pulse),
		.need_byte   (need_byte),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Predicted sequencer state and the register values it currently runs with.
	cfg_t                   cfg_now;
	phase_t                 ph;
	status_t                last_st;
	logic [15:0]            wait_cnt;
	logic [7:0]             sh_byte;
	logic [3:0]             bit_idx;
	logic [COUNT_WIDTH-1:0] byte_cnt;
	logic                   loaded;

	// Line levels still owed by the loader, oldest first.
	result_t pending_levels[$];

	int mismatch_count;
	int reported;
	int result_no;
	int burst_left;
	// Bumped by the stimulus when it wants the receiver to hold off for a long stretch.
	int hold_req;
	// Flavour of the sequence being generated: 0 cooperative FPGA, 1 init/done seldom
	// fall (reset wait tends to time out), 2 init seldom rises (init wait tends to time out).
	int mood;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// After reset the loader is idle with no end status; a no-op and a stray byte
		// change nothing.
		'{'{ACT_NOP,   8'h00, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, ST_NONE}},
		'{'{ACT_BYTE,  8'hFF, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, ST_NONE}},
		// Start pulls the program line low; a failing check keeps it in the reset wait.
		'{'{ACT_START, 8'h00, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, ST_BUSY}},
		'{'{ACT_STEP,  8'h00, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, ST_BUSY}},
		'{'{ACT_STEP,  8'h00, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, ST_BUSY}},
		// The release tick lets go of the program line whatever the lines read.
		'{'{ACT_STEP,  8'h00, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, ST_BUSY}},
		// Start while busy goes back to the reset wait.
		'{'{ACT_START, 8'hFF, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, ST_BUSY}},
		'{'{ACT_STEP,  8'h00, 1'b0, 1'b0}, 1'b0, '0},
		'{'{ACT_STEP,  8'h00, 1'b0, 1'b0}, 1'b0, '0},
		'{'{ACT_STEP,  8'h00, 1'b1, 1'b0}, 1'b0, '0},
		'{'{ACT_STEP,  8'h00, 1'b1, 1'b0}, 1'b0, '0},
		'{'{ACT_STEP,  8'h00, 1'b1, 1'b0}, 1'b0, '0},
		'{'{ACT_STEP,  8'h00, 1'b1, 1'b0}, 1'b0, '0},
		'{'{ACT_STEP,  8'h00, 1'b1, 1'b0}, 1'b0, '0},
		// A step with no byte loaded does nothing and keeps asking for a byte.
		'{'{ACT_STEP,  8'h00, 1'b1, 1'b0}, 1'b0, '0},
		'{'{ACT_BYTE,  8'hFF, 1'b1, 1'b0}, 1'b0, '0},
		// A second byte while one is still loaded is dropped.
		'{'{ACT_BYTE,  8'h00, 1'b1, 1'b0}, 1'b0, '0},
		'{'{ACT_STEP,  8'h00, 1'b1, 1'b0}, 1'b0, '0},
		// Init falling in mid-byte aborts; the no-op then shows the aborted status.
		'{'{ACT_STEP,  8'h00, 1'b0, 1'b0}, 1'b0, '0},
		'{'{ACT_NOP,   8'h00, 1'b0, 1'b0}, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Ends a sequence: back to idle with the program line released.
	function void close_seq(input status_t st);
		ph      = PH_IDLE;
		last_st = st;
		loaded  = 1'b0;
	endfunction

	// Advances the predicted sequencer by one item and returns the line levels it gives.
	task automatic predict_lines(input item_t it, output result_t lv);
		logic bit_out;
		logic clk_out;
		logic byte_end;
		bit_out = 1'b0;
		clk_out = 1'b0;
		case (it.action)
			ACT_START: begin
				ph       = PH_RESET_WAIT;
				wait_cnt = '0;
				sh_byte  = '0;
				bit_idx  = '0;
				byte_cnt = '0;
				loaded   = 1'b0;
			end
			ACT_BYTE: begin
				if (ph == PH_SHIFT && !loaded) begin
					sh_byte = it.byte_value;
					bit_idx = '0;
					loaded  = 1'b1;
				end
			end
			ACT_STEP: begin
				case (ph)
					PH_RESET_WAIT: begin
						if (!it.init_level && !it.done_level)
							ph = PH_RELEASE;
						else if (wait_cnt >= cfg_now.timeout_ticks)
							close_seq(ST_RESET_TIMEOUT);
						else
							wait_cnt = wait_cnt + 16'd1;
					end
					PH_RELEASE: begin
						ph       = PH_INIT_WAIT;
						wait_cnt = '0;
					end
					PH_INIT_WAIT: begin
						if (it.init_level) begin
							wait_cnt = '0;
							ph = (cfg_now.start_delay_ticks == 8'd0) ? PH_SHIFT : PH_DELAY;
						end else if (wait_cnt >= cfg_now.timeout_ticks) begin
							close_seq(ST_INIT_TIMEOUT);
						end else begin
							wait_cnt = wait_cnt + 16'd1;
						end
					end
					PH_DELAY: begin
						wait_cnt = wait_cnt + 16'd1;
						if (wait_cnt >= {8'd0, cfg_now.start_delay_ticks}) begin
							wait_cnt = '0;
							ph       = PH_SHIFT;
						end
					end
					PH_SHIFT: begin
						if (loaded) begin
							// MSB goes out first, with one clock pulse per bit.
							bit_out  = sh_byte[7];
							clk_out  = 1'b1;
							sh_byte  = {sh_byte[6:0], 1'b0};
							bit_idx  = bit_idx + 4'd1;
							byte_end = (bit_idx >= 4'd8) || it.done_level;
							if (byte_end) begin
								loaded  = 1'b0;
								bit_idx = '0;
								if (byte_cnt != COUNT_MAX)
									byte_cnt = byte_cnt + 1'b1;
							end
							if (it.done_level) begin
								wait_cnt = '0;
								if (cfg_now.trailing_clocks == 8'd0)
									close_seq(ST_SUCCESS);
								else
									ph = PH_TRAIL;
							end else if (!it.init_level) begin
								close_seq(ST_ABORTED);
							end else if (byte_end && byte_cnt > cfg_now.max_bytes) begin
								close_seq(ST_OVERRUN);
							end
						end
					end
					PH_TRAIL: begin
						clk_out  = 1'b1;
						wait_cnt = wait_cnt + 16'd1;
						if (wait_cnt >= {8'd0, cfg_now.trailing_clocks})
							close_seq(ST_SUCCESS);
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
		lv.prog_drive  = !(ph == PH_RESET_WAIT || ph == PH_RELEASE);
		lv.data_bit    = bit_out;
		lv.clock_pulse = clk_out;
		lv.need_byte   = (ph == PH_SHIFT) && !loaded;
		lv.status      = (ph == PH_IDLE) ? last_st : ST_BUSY;
	endtask

	// Builds the next random item. Most items follow a well-formed load so that runs reach
	// shifting and its endings; a small share is pure noise.
	function automatic item_t next_item();
		item_t it;
		int    r;
		it.byte_value = 8'($urandom_range(0, 255));
		it.init_level = 1'($urandom_range(0, 1));
		it.done_level = 1'($urandom_range(0, 1));
		it.action     = ACT_STEP;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			it.action = 2'($urandom_range(0, 3));
			return it;
		end
		case (ph)
			PH_IDLE: begin
				it.action = (r < 80) ? ACT_START : ACT_NOP;
				r    = $urandom_range(0, 9);
				mood = (r < 2) ? 1 : (r < 4) ? 2 : 0;
			end
			PH_RESET_WAIT: begin
				if ((mood == 1) ? (r < 15) : (r < 85)) begin
					it.init_level = 1'b0;
					it.done_level = 1'b0;
				end else if (!it.init_level && !it.done_level) begin
					it.done_level = 1'b1;
				end
			end
			PH_INIT_WAIT: begin
				it.init_level = (mood == 2) ? (r < 12) : (r < 75);
			end
			PH_SHIFT: begin
				if (!loaded) begin
					if (r < 90)
						it.action = ACT_BYTE;
				end else begin
					it.init_level = 1'b1;
					it.done_level = 1'b0;
					if (r < 9)
						it.done_level = 1'b1;
					else if (r < 11)
						it.init_level = 1'b0;
					else if (r < 14)
						it.action = ACT_BYTE;
					else if (r < 15)
						it.action = ACT_START;
				end
			end
			default: begin
			end
		endcase
		return it;
	endfunction

	// Sender pacing: bursts of random length separated by random gaps, some of them empty.
	task automatic pace();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	// Offers one item, waits for it to be taken and records the levels it must produce.
	task automatic offer(input item_t it, input logic typed, input result_t want);
		result_t lv;
		@(negedge clk);
		in_valid   <= 1'b1;
		action     <= it.action;
		byte_value <= it.byte_value;
		init_level <= it.init_level;
		done_level <= it.done_level;
		do @(posedge clk); while (in_stall);
		predict_lines(it, lv);
		pending_levels.push_back(typed ? want : lv);
		pace();
	endtask

	// Stops offering and waits until every owed result has come back, so that the loader is
	// idle and its registers may be rewritten.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TIMEOUT_TICKS:     cfg_now.timeout_ticks     = val[15:0];
			CFG_MAX_BYTES:         cfg_now.max_bytes         = val[23:0];
			CFG_START_DELAY_TICKS: cfg_now.start_delay_ticks = val[7:0];
			CFG_TRAILING_CLOCKS:   cfg_now.trailing_clocks   = val[7:0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_cfg(input cfg_t c);
		write_reg(CFG_TIMEOUT_TICKS,     {8'd0, c.timeout_ticks});
		write_reg(CFG_MAX_BYTES,         c.max_bytes);
		write_reg(CFG_START_DELAY_TICKS, {16'd0, c.start_delay_ticks});
		write_reg(CFG_TRAILING_CLOCKS,   {16'd0, c.trailing_clocks});
	endtask

	// Receiver: stall pattern in stretches of random length (none, light, heavy), plus a long
	// hold-off whenever the stimulus asks for one, during which the sender keeps offering.
	initial begin
		int hold_seen;
		int hold_left;
		int mode;
		int mode_left;
		hold_seen = 0;
		hold_left = 0;
		mode      = 0;
		mode_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(1, 40);
				end
				mode_left--;
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Every result taken is matched against the oldest owed one.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{prog_drive, data_bit, clock_pulse, need_byte, status};
			if (pending_levels.size() == 0) begin
				mismatch_count++;
				if (reported < 10) begin
					reported++;
					$write("result %0d arrived with nothing owed: ", result_no);
					$display("prog=%b bit=%b clk=%b need=%b st=%0d",
						got.prog_drive, got.data_bit, got.clock_pulse,
						got.need_byte, got.status);
				end
			end else begin
				want = pending_levels.pop_front();
				if (got.prog_drive !== want.prog_drive || got.data_bit !== want.data_bit ||
				    got.clock_pulse !== want.clock_pulse || got.need_byte !== want.need_byte ||
				    got.status !== want.status) begin
					mismatch_count++;
					if (reported < 10) begin
						reported++;
						$write("result %0d: want prog=%b bit=%b clk=%b need=%b st=%0d, ",
							result_no, want.prog_drive, want.data_bit, want.clock_pulse,
							want.need_byte, want.status);
						$display("got prog=%b bit=%b clk=%b need=%b st=%0d",
							got.prog_drive, got.data_bit, got.clock_pulse,
							got.need_byte, got.status);
					end
				end
			end
			result_no++;
		end
	end

	// Watchdog: any accepted item, result or register write counts as progress.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("testbench NOT OK");
		$finish;
	end

	// Main stimulus: reset, the directed table with the reset register values, then phases of
	// random loads, each under a register setting written while the loader is idle.
	initial begin
		cfg_t plan [PHASE_COUNT];
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		action         = ACT_NOP;
		byte_value     = '0;
		init_level     = 1'b0;
		done_level     = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_TIMEOUT_TICKS;
		cfg_data       = '0;
		mismatch_count = 0;
		reported       = 0;
		result_no      = 0;
		burst_left     = 1;
		hold_req       = 0;
		mood           = 0;

		cfg_now.timeout_ticks     = RST_TIMEOUT_TICKS;
		cfg_now.max_bytes         = RST_MAX_BYTES;
		cfg_now.start_delay_ticks = RST_START_DELAY_TICKS;
		cfg_now.trailing_clocks   = RST_TRAILING_CLOCKS;
		ph       = PH_IDLE;
		last_st  = ST_NONE;
		wait_cnt = '0;
		sh_byte  = '0;
		bit_idx  = '0;
		byte_cnt = '0;
		loaded   = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++)
			offer(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		drain();

		// Smallest limits first (zero delays, one-byte overrun, one-tick timeout), then the
		// largest, then a small fixed mix and random small settings that keep loads short.
		plan[0] = '{16'd1, 24'd1, 8'd0, 8'd0};
		plan[1] = '{16'hFFFF, 24'hFFFFFF, 8'hFF, 8'hFF};
		plan[2] = '{16'd2, 24'd3, 8'd1, 8'd1};
		for (int p = 3; p < PHASE_COUNT; p++) begin
			plan[p].timeout_ticks     = 16'($urandom_range(1, 6));
			plan[p].max_bytes         = 24'($urandom_range(1, 8));
			plan[p].start_delay_ticks = 8'($urandom_range(0, 6));
			plan[p].trailing_clocks   = 8'($urandom_range(0, 6));
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			load_cfg(plan[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Mid-phase, the receiver is asked to hold off so that the loader fills up.
				if ((p == 2 || p == 5) && i == 50)
					hold_req++;
				offer(next_item(), 1'b0, '0);
			end
			drain();
		end

		// Nothing is owed now; the closing wait shows that no stray result follows.
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_levels.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
